[sv/variable_partition_allocator_assert.svh]
// assertion macros for the partition allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH

// condition holds in the same cycle
`define VPA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("partition allocator check failed");

// condition holds in the following cycle
`define VPA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("partition allocator check failed");

`endif

[sv/vpa_pkg.sv]
// types and constants shared by the partition allocator modules
package vpa_pkg;

   localparam int REQ_SIZE_W = 10;
   localparam int OWNER_W    = 8;
   localparam int BASE_W     = 10;
   localparam int STATUS_W   = 3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADSIZE  = 3'd4;

   typedef struct packed {
      logic                  operation;
      logic [1:0]            fit_policy;
      logic [OWNER_W-1:0]    owner_id;
      logic [REQ_SIZE_W-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BASE_W-1:0]   base_address;
   } rsp_type;

   typedef enum logic [2:0] {
      RD_SCAN,
      RD_SHIFT,
      RD_NEXT,
      RD_PREV,
      RD_DROP
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,
      WR_SHIFT,
      WR_SPLIT_HI,
      WR_SPLIT_LO,
      WR_EXACT,
      WR_CUR,
      WR_PREV
   } wr_sel_type;

   typedef struct packed {
      rd_sel_type          rd_sel;
      wr_sel_type          wr_sel;
      logic                load;
      logic                scan_ev;
      logic                exact_fin;
      logic                split_start;
      logic                k_dec;
      logic                split_fin;
      logic                merge_next;
      logic                merge_prev;
      logic                k_inc;
      logic                drop_end;
      logic                res_set;
      logic [STATUS_W-1:0] res_code;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic scan_done;
      logic hit;
      logic found;
      logic exact;
      logic full;
      logic shift_more;
      logic has_next;
      logic has_prev;
      logic nb_free;
      logic drop_more;
   } sts_type;

endpackage

[sv/variable_partition_allocator.sv]
// top level of the variable partition allocator
//
// Requests arrive on req_* (valid/stall): allocate a partition of request_size
// for owner_id with first, best, worst or next fit, or free the owner's lowest
// used partition and merge it with free neighbors. Each request yields one
// transfer on rsp_* with a status and, for a successful allocation, the base.
// The partition table sits in a single-port-write RAM; each table entry visit
// is an address step, then registered data. An allocation scans entries,
// then on a split moves entries up and writes both halves of the split. A
// free scans entries, then moves entries down on each merge.
// One request is in flight at a time; the next is taken while the previous
// result still waits on rsp_stall, and the finished result holds until the
// output register is free.
// After reset the block writes the initial free partition in S_INIT with
// req_stall high, then the table holds one free partition of all memory.
module variable_partition_allocator #(
   parameter int MEMORY_SIZE  = 640,
   parameter int MAX_SEGMENTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vpa_pkg::rsp_type rsp_data
);

`include "variable_partition_allocator_assert.svh"

   vpa_pkg::cmd_type cmd;
   vpa_pkg::sts_type sts;

   vpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vpa_datapath #(
      .MEMORY_SIZE  (MEMORY_SIZE),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   `VPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `VPA_ASSERT_NOW(a_load_when_free, clock, reset, cmd.rsp_load, !rsp_valid || !rsp_stall)
   `VPA_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_data.status <= vpa_pkg::ST_BADSIZE)

endmodule

[sv/vpa_ram.sv]
// generic single write port ram with registered read
module vpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/vpa_controller.sv]
// sequencer for scan, split, merge and result transfer
module vpa_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  vpa_pkg::sts_type sts,
   output vpa_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SCAN_END,
      S_SH_RD,
      S_SH_WR,
      S_SPLIT_HI,
      S_SPLIT_LO,
      S_NX_RD,
      S_NX_EV,
      S_DR_RD,
      S_DR_WR,
      S_PV_RD,
      S_PV_EV,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      ret_ff, ret_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      ret_in       = ret_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_INIT: begin
            cmd.wr_sel = vpa_pkg::WR_INIT;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.is_free && sts.bad_size) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = vpa_pkg::ST_BADSIZE;
               state_in     = S_RESULT;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_sel = vpa_pkg::RD_SCAN;
            if (sts.scan_done) begin
               if (sts.is_free) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = vpa_pkg::ST_NOTFOUND;
                  state_in     = S_RESULT;
               end else begin
                  state_in = S_SCAN_END;
               end
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            if (sts.hit) begin
               state_in = sts.is_free ? S_NX_RD : S_SCAN_END;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            if (!sts.found) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = vpa_pkg::ST_NOFIT;
               state_in     = S_RESULT;
            end else if (sts.exact) begin
               cmd.wr_sel    = vpa_pkg::WR_EXACT;
               cmd.exact_fin = 1'b1;
               cmd.res_set   = 1'b1;
               cmd.res_code  = vpa_pkg::ST_OK;
               state_in      = S_RESULT;
            end else if (sts.full) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = vpa_pkg::ST_FULL;
               state_in     = S_RESULT;
            end else begin
               cmd.split_start = 1'b1;
               state_in        = S_SH_RD;
            end
         end
         S_SH_RD: begin
            if (sts.shift_more) begin
               cmd.rd_sel = vpa_pkg::RD_SHIFT;
               state_in   = S_SH_WR;
            end else begin
               state_in = S_SPLIT_HI;
            end
         end
         S_SH_WR: begin
            cmd.wr_sel = vpa_pkg::WR_SHIFT;
            cmd.k_dec  = 1'b1;
            state_in   = S_SH_RD;
         end
         S_SPLIT_HI: begin
            cmd.wr_sel = vpa_pkg::WR_SPLIT_HI;
            state_in   = S_SPLIT_LO;
         end
         S_SPLIT_LO: begin
            cmd.wr_sel    = vpa_pkg::WR_SPLIT_LO;
            cmd.split_fin = 1'b1;
            cmd.res_set   = 1'b1;
            cmd.res_code  = vpa_pkg::ST_OK;
            state_in      = S_RESULT;
         end
         S_NX_RD: begin
            if (sts.has_next) begin
               cmd.rd_sel = vpa_pkg::RD_NEXT;
               state_in   = S_NX_EV;
            end else begin
               state_in = S_PV_RD;
            end
         end
         S_NX_EV: begin
            if (sts.nb_free) begin
               cmd.merge_next = 1'b1;
               ret_in         = 1'b0;
               state_in       = S_DR_RD;
            end else begin
               state_in = S_PV_RD;
            end
         end
         S_DR_RD: begin
            if (sts.drop_more) begin
               cmd.rd_sel = vpa_pkg::RD_DROP;
               state_in   = S_DR_WR;
            end else begin
               cmd.drop_end = 1'b1;
               if (ret_ff) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = vpa_pkg::ST_OK;
                  state_in     = S_RESULT;
               end else begin
                  state_in = S_PV_RD;
               end
            end
         end
         S_DR_WR: begin
            cmd.wr_sel = vpa_pkg::WR_SHIFT;
            cmd.k_inc  = 1'b1;
            state_in   = S_DR_RD;
         end
         S_PV_RD: begin
            if (sts.has_prev) begin
               cmd.rd_sel = vpa_pkg::RD_PREV;
               state_in   = S_PV_EV;
            end else begin
               cmd.wr_sel   = vpa_pkg::WR_CUR;
               cmd.res_set  = 1'b1;
               cmd.res_code = vpa_pkg::ST_OK;
               state_in     = S_RESULT;
            end
         end
         S_PV_EV: begin
            if (sts.nb_free) begin
               cmd.wr_sel     = vpa_pkg::WR_PREV;
               cmd.merge_prev = 1'b1;
               ret_in         = 1'b1;
               state_in       = S_DR_RD;
            end else begin
               cmd.wr_sel   = vpa_pkg::WR_CUR;
               cmd.res_set  = 1'b1;
               cmd.res_code = vpa_pkg::ST_OK;
               state_in     = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         ret_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ret_ff       <= ret_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/vpa_datapath.sv]
// partition table memory, scan registers and result register
module vpa_datapath #(
   parameter int MEMORY_SIZE  = 640,
   parameter int MAX_SEGMENTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  vpa_pkg::req_type req_data,
   input  vpa_pkg::cmd_type cmd,
   output vpa_pkg::sts_type sts,
   output vpa_pkg::rsp_type rsp_data
);

   localparam int AW    = $clog2(MAX_SEGMENTS);
   localparam int CW    = $clog2(MAX_SEGMENTS + 1);
   localparam int SW    = $clog2(MEMORY_SIZE + 1);
   localparam int CMP_W = (SW > vpa_pkg::REQ_SIZE_W) ? SW : vpa_pkg::REQ_SIZE_W;

   typedef struct packed {
      logic [SW-1:0]               base;
      logic [SW-1:0]               size;
      logic [vpa_pkg::OWNER_W-1:0] owner;
      logic                        used;
   } entry_type;

   localparam int EW = $bits(entry_type);

   vpa_pkg::req_type              req_ff;
   logic [CW-1:0]                 cnt_ff;
   logic [AW-1:0]                 rover_ff, rover_in;
   logic [CW-1:0]                 n_ff;
   logic [CW-1:0]                 k_ff;
   logic [AW-1:0]                 drop_r_ff;
   logic                          found_ff;
   logic [AW-1:0]                 pick_ff;
   logic [CMP_W-1:0]              left_ff;
   entry_type                     pick_ent_ff;
   entry_type                     cur_ent_ff;
   logic [vpa_pkg::STATUS_W-1:0]  res_status_ff;
   logic [SW-1:0]                 res_base_ff;
   vpa_pkg::rsp_type              rsp_ff;

   logic [EW-1:0]    ram_rd_data;
   entry_type        rd_ent;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_ent;
   logic [AW-1:0]    rd_addr;
   logic [CW:0]      rov_sum;
   logic [CW:0]      rov_wrap;
   logic [AW-1:0]    scan_idx;
   logic [CW-1:0]    pick_c;
   logic [CW-1:0]    next_c;
   logic [CMP_W-1:0] req_c;
   logic [CMP_W-1:0] ent_c;
   logic [CMP_W-1:0] diff;
   logic             fits;
   logic             match;
   logic             next_fit;
   logic [AW-1:0]    rover_dec;
   logic [SW-1:0]    req_s;

   assign rd_ent   = entry_type'(ram_rd_data);
   assign next_fit = (req_ff.fit_policy == vpa_pkg::FIT_NEXT);
   assign rov_sum  = (CW+1)'(rover_ff) + (CW+1)'(n_ff);
   assign rov_wrap = (rov_sum >= (CW+1)'(cnt_ff)) ? rov_sum - (CW+1)'(cnt_ff) : rov_sum;
   assign scan_idx = (req_ff.operation == vpa_pkg::OP_ALLOC && next_fit)
                     ? AW'(rov_wrap) : AW'(n_ff);
   assign pick_c   = CW'(pick_ff);
   assign next_c   = pick_c + CW'(1);
   assign req_c    = CMP_W'(req_ff.request_size);
   assign ent_c    = CMP_W'(rd_ent.size);
   assign diff     = ent_c - req_c;
   assign fits     = !rd_ent.used && (ent_c >= req_c);
   assign match    = rd_ent.used && (rd_ent.owner == req_ff.owner_id);
   assign req_s    = SW'(req_ff.request_size);

   always_comb begin
      case (cmd.rd_sel)
         vpa_pkg::RD_SCAN:  rd_addr = scan_idx;
         vpa_pkg::RD_SHIFT: rd_addr = AW'(k_ff - CW'(1));
         vpa_pkg::RD_NEXT:  rd_addr = AW'(next_c);
         vpa_pkg::RD_PREV:  rd_addr = pick_ff - AW'(1);
         vpa_pkg::RD_DROP:  rd_addr = AW'(k_ff + CW'(1));
         default:           rd_addr = scan_idx;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = pick_ff;
      wr_ent  = cur_ent_ff;
      case (cmd.wr_sel)
         vpa_pkg::WR_NONE: begin
            wr_en = 1'b0;
         end
         vpa_pkg::WR_INIT: begin
            wr_addr = '0;
            wr_ent  = '{base: '0, size: SW'(MEMORY_SIZE), owner: '0, used: 1'b0};
         end
         vpa_pkg::WR_SHIFT: begin
            wr_addr = AW'(k_ff);
            wr_ent  = rd_ent;
         end
         vpa_pkg::WR_SPLIT_HI: begin
            wr_addr = AW'(next_c);
            wr_ent  = '{base: pick_ent_ff.base + req_s, size: pick_ent_ff.size - req_s,
                        owner: '0, used: 1'b0};
         end
         vpa_pkg::WR_SPLIT_LO: begin
            wr_ent = '{base: pick_ent_ff.base, size: req_s, owner: req_ff.owner_id,
                       used: 1'b1};
         end
         vpa_pkg::WR_EXACT: begin
            wr_ent = '{base: pick_ent_ff.base, size: pick_ent_ff.size,
                       owner: req_ff.owner_id, used: 1'b1};
         end
         vpa_pkg::WR_CUR: begin
            wr_ent = cur_ent_ff;
         end
         vpa_pkg::WR_PREV: begin
            wr_addr = pick_ff - AW'(1);
            wr_ent  = '{base: rd_ent.base, size: rd_ent.size + cur_ent_ff.size,
                        owner: rd_ent.owner, used: 1'b0};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // rover follows its partition across splits and merges; in next fit it moves past the allocated partition
   always_comb begin
      rover_in  = rover_ff;
      rover_dec = (rover_ff >= drop_r_ff && rover_ff != '0) ? rover_ff - AW'(1) : rover_ff;
      if (cmd.load && CW'(rover_ff) >= cnt_ff) begin
         rover_in = '0;
      end else if (cmd.exact_fin && next_fit) begin
         rover_in = (next_c >= cnt_ff) ? '0 : AW'(next_c);
      end else if (cmd.split_fin) begin
         if (next_fit) begin
            rover_in = AW'(next_c);
         end else if (rover_ff >= pick_ff) begin
            rover_in = rover_ff + AW'(1);
         end
      end else if (cmd.drop_end) begin
         rover_in = (CW'(rover_dec) >= cnt_ff - CW'(1)) ? '0 : rover_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= CW'(1);
         rover_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         rover_ff <= rover_in;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end
         if (cmd.scan_ev && req_ff.operation == vpa_pkg::OP_ALLOC && fits) begin
            found_ff <= 1'b1;
         end
         if (cmd.split_fin) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (cmd.drop_end) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         n_ff   <= '0;
      end
      if (cmd.scan_ev) begin
         n_ff <= n_ff + CW'(1);
         if (req_ff.operation == vpa_pkg::OP_FREE) begin
            if (match) begin
               pick_ff    <= scan_idx;
               cur_ent_ff <= '{base: rd_ent.base, size: rd_ent.size, owner: '0, used: 1'b0};
            end
         end else if (fits) begin
            if (!found_ff
                || (req_ff.fit_policy == vpa_pkg::FIT_BEST && diff < left_ff)
                || (req_ff.fit_policy == vpa_pkg::FIT_WORST && diff > left_ff)) begin
               pick_ff     <= scan_idx;
               left_ff     <= diff;
               pick_ent_ff <= rd_ent;
            end
         end
      end
      if (cmd.split_start) begin
         k_ff <= cnt_ff;
      end
      if (cmd.k_dec) begin
         k_ff <= k_ff - CW'(1);
      end
      if (cmd.k_inc) begin
         k_ff <= k_ff + CW'(1);
      end
      if (cmd.merge_next) begin
         cur_ent_ff.size <= cur_ent_ff.size + rd_ent.size;
         k_ff            <= next_c;
         drop_r_ff       <= AW'(next_c);
      end
      if (cmd.merge_prev) begin
         k_ff      <= pick_c;
         drop_r_ff <= pick_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         res_base_ff   <= (cmd.res_code == vpa_pkg::ST_OK
                           && req_ff.operation == vpa_pkg::OP_ALLOC)
                          ? pick_ent_ff.base : '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= '{status: res_status_ff, base_address: vpa_pkg::BASE_W'(res_base_ff)};
      end
   end

   vpa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_ent)),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      sts.is_free    = (req_ff.operation == vpa_pkg::OP_FREE);
      sts.bad_size   = (req_ff.request_size == '0);
      sts.scan_done  = (n_ff == cnt_ff);
      sts.hit        = (req_ff.operation == vpa_pkg::OP_FREE) ? match
                       : (fits && !found_ff
                          && (req_ff.fit_policy == vpa_pkg::FIT_FIRST || next_fit));
      sts.found      = found_ff;
      sts.exact      = (left_ff == '0);
      sts.full       = (cnt_ff == CW'(MAX_SEGMENTS));
      sts.shift_more = (k_ff > next_c);
      sts.has_next   = (next_c < cnt_ff);
      sts.has_prev   = (pick_ff != '0);
      sts.nb_free    = !rd_ent.used;
      sts.drop_more  = ((k_ff + CW'(1)) < cnt_ff);
   end

   assign rsp_data = rsp_ff;

endmodule
